### sv/ksmn_pkg.sv
`default_nettype none
package ksmn_pkg;

	localparam int KEYS_DEF     = 12;
	localparam int LEVELS_W     = 12;
	localparam int COUNT_W      = 4;
	localparam int NOTE_W       = 7;
	localparam int STATUS_W     = 8;
	localparam int CFG_DATA_W   = 7;
	localparam int CFG_INDEX_W  = 2;

	localparam logic [STATUS_W-1:0] NOTE_ON  = 8'h90;
	localparam logic [STATUS_W-1:0] NOTE_OFF = 8'h80;
	localparam logic [NOTE_W-1:0]   NOTE_MAX = 7'd127;

	localparam logic [COUNT_W-1:0] ACTIVE_KEYS_RST    = 4'd12;
	localparam logic [NOTE_W-1:0]  BASE_NOTE_RST      = 7'd61;
	localparam logic [NOTE_W-1:0]  PRESS_VELOCITY_RST = 7'd100;

	localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_KEYS    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BASE_NOTE      = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PRESS_VELOCITY = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} ksmn_state_t;

	typedef struct packed {
		logic load;
		logic advance;
		logic emit;
	} ksmn_cmd_t;

	typedef struct packed {
		logic edge_here;
		logic none_left;
		logic out_free;
	} ksmn_sts_t;

endpackage
`default_nettype wire

### sv/key_scan_to_midi_note_events.sv
// Key scan to MIDI note event encoder.
// Input channel (in_valid / in_stall) carries one beat per scan: key_levels,
// bit i the level of key i. Output channel (out_valid / out_stall) carries one
// beat per MIDI message: status_byte, note_number, velocity and last_event,
// which marks the final message of a scan. A scan with no level change gives
// no beat at all. Messages leave in ascending key order.
// Configuration: cfg_write with cfg_index 0 (active_keys), 1 (base_note),
// 2 (press_velocity) and cfg_data; write only while the block is idle.
// Timing: after a scan beat is taken the controller walks the scanned keys,
// one key per cycle unless out_stall holds it, from key 0 up to the highest
// changed key; the next scan beat is taken once the walk ends, and a scan
// with no change ends it without visiting a key. The message of a key is
// registered when the walk reaches it. in_stall is high for the whole walk.
// Back-pressure: out_stall holds the output register and pauses the walk on
// the next changed key; nothing is lost or repeated.
// Reset: all stored key levels go high, active_keys 12, base_note 61,
// press_velocity 100, no beat pending.
`default_nettype none
module key_scan_to_midi_note_events #(
	parameter int KEYS = ksmn_pkg::KEYS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_write,
	input  wire logic [ksmn_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [ksmn_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [ksmn_pkg::LEVELS_W-1:0]     key_levels,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [ksmn_pkg::STATUS_W-1:0]          status_byte,
	output logic [ksmn_pkg::NOTE_W-1:0]            note_number,
	output logic [ksmn_pkg::NOTE_W-1:0]            velocity,
	output logic                                   last_event
);
	import ksmn_pkg::*;

	ksmn_cmd_t cmd;
	ksmn_sts_t sts;

	ksmn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ksmn_dp #(
		.KEYS (KEYS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.key_levels  (key_levels),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status_byte (status_byte),
		.note_number (note_number),
		.velocity    (velocity),
		.last_event  (last_event)
	);

endmodule
`default_nettype wire

### sv/ksmn_ctrl.sv
`default_nettype none
module ksmn_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire ksmn_pkg::ksmn_sts_t   sts,
	output ksmn_pkg::ksmn_cmd_t        cmd
);
	import ksmn_pkg::*;

	ksmn_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.none_left) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall    = 1'b1;
		cmd.load    = 1'b0;
		cmd.advance = 1'b0;
		cmd.emit    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_SCAN: begin
				if (!sts.none_left) begin
					cmd.emit    = sts.edge_here & sts.out_free;
					cmd.advance = !sts.edge_here | sts.out_free;
				end
			end
			default: in_stall = 1'b1;
		endcase
	end

endmodule
`default_nettype wire

### sv/ksmn_dp.sv
`default_nettype none
module ksmn_dp #(
	parameter int KEYS = ksmn_pkg::KEYS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_write,
	input  wire logic [ksmn_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [ksmn_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic [ksmn_pkg::LEVELS_W-1:0]        key_levels,
	input  wire ksmn_pkg::ksmn_cmd_t                  cmd,
	output ksmn_pkg::ksmn_sts_t                       sts,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [ksmn_pkg::STATUS_W-1:0]             status_byte,
	output logic [ksmn_pkg::NOTE_W-1:0]               note_number,
	output logic [ksmn_pkg::NOTE_W-1:0]               velocity,
	output logic                                      last_event
);
	import ksmn_pkg::*;

	localparam int SCAN_W = (KEYS < LEVELS_W) ? KEYS : LEVELS_W;
	localparam int IDX_W  = (SCAN_W > 1) ? $clog2(SCAN_W) : 1;
	localparam int N_W    = COUNT_W + 1;

	logic [COUNT_W-1:0]  active_keys_q;
	logic [NOTE_W-1:0]   base_note_q;
	logic [NOTE_W-1:0]   press_velocity_q;
	logic [SCAN_W-1:0]   prev_levels_q;
	logic [SCAN_W-1:0]   levels_q;
	logic [SCAN_W-1:0]   diff_q;
	logic [IDX_W-1:0]    key_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [NOTE_W-1:0]   note_q;
	logic [NOTE_W-1:0]   velocity_q;
	logic                last_q;

	logic [N_W-1:0]      scan_n;
	logic [SCAN_W-1:0]   scan_mask;
	logic [SCAN_W-1:0]   scan_levels;
	logic [SCAN_W-1:0]   key_bit;
	logic [SCAN_W-1:0]   diff_rest;
	logic [NOTE_W:0]     note_sum;
	logic [NOTE_W-1:0]   note_sat;

	always_comb begin
		scan_n = (N_W'(active_keys_q) > N_W'(SCAN_W)) ? N_W'(SCAN_W) : N_W'(active_keys_q);
		for (int i = 0; i < SCAN_W; i++) begin
			scan_mask[i] = N_W'(i) < scan_n;
		end
	end

	assign scan_levels = key_levels[SCAN_W-1:0];
	assign key_bit     = SCAN_W'(1) << key_q;
	assign diff_rest   = diff_q & ~key_bit;
	assign note_sum    = (NOTE_W+1)'(base_note_q) + (NOTE_W+1)'(key_q);
	assign note_sat    = note_sum[NOTE_W] ? NOTE_MAX : note_sum[NOTE_W-1:0];

	assign sts.edge_here = diff_q[key_q];
	assign sts.none_left = (diff_q == '0);
	assign sts.out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_keys_q    <= ACTIVE_KEYS_RST;
			base_note_q      <= BASE_NOTE_RST;
			press_velocity_q <= PRESS_VELOCITY_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ACTIVE_KEYS:    active_keys_q    <= cfg_data[COUNT_W-1:0];
				REG_BASE_NOTE:      base_note_q      <= cfg_data[NOTE_W-1:0];
				REG_PRESS_VELOCITY: press_velocity_q <= cfg_data[NOTE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_levels_q <= '1;
			diff_q        <= '0;
			key_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				diff_q        <= (scan_levels ^ prev_levels_q) & scan_mask;
				prev_levels_q <= (prev_levels_q & ~scan_mask) | (scan_levels & scan_mask);
				key_q         <= '0;
			end else begin
				if (cmd.emit) diff_q <= diff_rest;
				if (cmd.advance) key_q <= key_q + IDX_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) levels_q <= scan_levels;
		if (cmd.emit) begin
			status_q   <= levels_q[key_q] ? NOTE_ON : NOTE_OFF;
			velocity_q <= levels_q[key_q] ? press_velocity_q : '0;
			note_q     <= note_sat;
			last_q     <= (diff_rest == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign status_byte = status_q;
	assign note_number = note_q;
	assign velocity    = velocity_q;
	assign last_event  = last_q;

endmodule
`default_nettype wire
